FILE: src/irpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types, codes and constants of the pulse distance frame encoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

  localparam int DUR_W  = 16;
  localparam int IDX_W  = 3;
  localparam int BYTE_W = 8;

  // item kinds
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_DATA  = 2'd1;
  localparam logic [1:0] MODE_END   = 2'd2;

  // register indexes on the configuration port
  localparam logic [IDX_W-1:0] CFG_HDR_MARK  = 3'd0;
  localparam logic [IDX_W-1:0] CFG_HDR_SPACE = 3'd1;
  localparam logic [IDX_W-1:0] CFG_BIT_MARK  = 3'd2;
  localparam logic [IDX_W-1:0] CFG_ONE_SPACE = 3'd3;
  localparam logic [IDX_W-1:0] CFG_ZERO_SPACE = 3'd4;
  localparam logic [IDX_W-1:0] CFG_TRL_MARK  = 3'd5;

  // register reset values in microseconds
  localparam logic [DUR_W-1:0] RST_HDR_MARK   = 16'd3350;
  localparam logic [DUR_W-1:0] RST_HDR_SPACE  = 16'd1650;
  localparam logic [DUR_W-1:0] RST_BIT_MARK   = 16'd450;
  localparam logic [DUR_W-1:0] RST_ONE_SPACE  = 16'd1250;
  localparam logic [DUR_W-1:0] RST_ZERO_SPACE = 16'd400;
  localparam logic [DUR_W-1:0] RST_TRL_MARK   = 16'd430;

  // last byte position of a frame start (three sync bytes) and a data item
  localparam logic [1:0] SYNC_LAST_IDX = 2'd2;
  localparam logic [1:0] DATA_LAST_IDX = 2'd1;

  localparam logic [BYTE_W-1:0] BYTE_INV_MASK = 8'hff;

  typedef struct packed {
    logic [DUR_W-1:0] hdr_mark;
    logic [DUR_W-1:0] hdr_space;
    logic [DUR_W-1:0] bit_mark;
    logic [DUR_W-1:0] one_space;
    logic [DUR_W-1:0] zero_space;
    logic [DUR_W-1:0] trl_mark;
  } irpd_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR_MARK,
    ST_HDR_SPACE,
    ST_BIT_MARK,
    ST_BIT_SPACE,
    ST_TRL_MARK
  } irpd_state_t;

  function automatic logic [BYTE_W-1:0] sync_byte(input logic [1:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      2'd0:    b = 8'h01;
      2'd1:    b = 8'h10;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

FILE: src/irpd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irpd input and output channels
// Valid/ready channels carrying the item and the duration words.
// ----------------------------------------------------------------------------
interface irpd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface irpd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] duration_us;
  logic        is_mark;
  logic        last;

  modport source (output valid, output duration_us, output is_mark, output last,
                  input ready);
  modport sink   (input valid, input duration_us, input is_mark, input last,
                  output ready);
endinterface
`default_nettype wire

FILE: src/irpd_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irpd_cfg_regs
// Duration register file written through the configuration port.
// ----------------------------------------------------------------------------
module irpd_cfg_regs
  import irpd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [DUR_W-1:0] cfg_wdata,
  output irpd_cfg_t             cfg
);

  irpd_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hdr_mark   <= RST_HDR_MARK;
      cfg_r.hdr_space  <= RST_HDR_SPACE;
      cfg_r.bit_mark   <= RST_BIT_MARK;
      cfg_r.one_space  <= RST_ONE_SPACE;
      cfg_r.zero_space <= RST_ZERO_SPACE;
      cfg_r.trl_mark   <= RST_TRL_MARK;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HDR_MARK:   cfg_r.hdr_mark   <= cfg_wdata;
        CFG_HDR_SPACE:  cfg_r.hdr_space  <= cfg_wdata;
        CFG_BIT_MARK:   cfg_r.bit_mark   <= cfg_wdata;
        CFG_ONE_SPACE:  cfg_r.one_space  <= cfg_wdata;
        CFG_ZERO_SPACE: cfg_r.zero_space <= cfg_wdata;
        CFG_TRL_MARK:   cfg_r.trl_mark   <= cfg_wdata;
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

FILE: src/ir_pulse_distance_frame_encoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_encoder_core
// Pulse distance infrared frame encoder with complemented data bytes.
// ----------------------------------------------------------------------------
// Each accepted item is expanded into mark/space duration words, one word per
// cycle while the output side keeps taking them: a frame start gives 50 words
// (header mark and space, then sync bytes 0x01, 0x10, 0x00), a data byte 32
// words (the byte LSB first, then its complement) and a frame end a single
// trailer mark; mode 3 is taken and dropped. The item is accepted while the
// sequencer is idle and its words follow, each held while the output stalls.
// The pace is set by the sequencer, which steps one shared 8-bit shift
// register bit by bit, one word per step. A new item is taken only after
// the previous one has handed over its last word to the output register.
// Durations come from six 16-bit registers on the cfg_ port; the user must
// write them only while the block is idle, the block does not enforce it.
// ----------------------------------------------------------------------------
module ir_pulse_distance_frame_encoder_core
  import irpd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  irpd_in_if.sink               in_if,
  irpd_out_if.source            out_if,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [DUR_W-1:0] cfg_wdata
);

  irpd_cfg_t cfg;

  irpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  irpd_state_t       state_r, state_nxt;
  logic [BYTE_W-1:0] shift_r, shift_nxt;
  logic [BYTE_W-1:0] data_r, data_nxt;
  logic [2:0]        bit_cnt_r, bit_cnt_nxt;
  logic [1:0]        byte_idx_r, byte_idx_nxt;
  logic              is_sync_r, is_sync_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [DUR_W-1:0]  out_dur_r, out_dur_nxt;
  logic              out_mark_r, out_mark_nxt;
  logic              out_last_r, out_last_nxt;

  logic              in_fire;
  logic              can_emit;
  logic              load;
  logic              final_byte;

  assign in_fire    = in_if.valid && in_if.ready;
  assign can_emit   = !out_valid_r || out_if.ready;
  assign final_byte = is_sync_r ? (byte_idx_r == SYNC_LAST_IDX)
                                : (byte_idx_r == DATA_LAST_IDX);

  always_comb begin
    state_nxt    = state_r;
    shift_nxt    = shift_r;
    data_nxt     = data_r;
    bit_cnt_nxt  = bit_cnt_r;
    byte_idx_nxt = byte_idx_r;
    is_sync_nxt  = is_sync_r;
    in_if.ready  = 1'b0;
    load         = 1'b0;
    out_dur_nxt  = out_dur_r;
    out_mark_nxt = out_mark_r;
    out_last_nxt = out_last_r;

    if (state_r == ST_IDLE) begin
      in_if.ready = 1'b1;
      if (in_if.valid) begin
        case (in_if.mode)
          MODE_START: begin
            is_sync_nxt = 1'b1;
            state_nxt   = ST_HDR_MARK;
          end
          MODE_DATA: begin
            is_sync_nxt  = 1'b0;
            shift_nxt    = in_if.data_byte;
            data_nxt     = in_if.data_byte;
            byte_idx_nxt = 2'd0;
            bit_cnt_nxt  = 3'd0;
            state_nxt    = ST_BIT_MARK;
          end
          MODE_END: state_nxt = ST_TRL_MARK;
          default:  state_nxt = ST_IDLE; // unused kind, no words
        endcase
      end
    end else if (can_emit) begin
      load         = 1'b1;
      out_last_nxt = 1'b0;
      case (state_r)
        ST_HDR_MARK: begin
          out_dur_nxt  = cfg.hdr_mark;
          out_mark_nxt = 1'b1;
          state_nxt    = ST_HDR_SPACE;
        end
        ST_HDR_SPACE: begin
          out_dur_nxt  = cfg.hdr_space;
          out_mark_nxt = 1'b0;
          shift_nxt    = sync_byte(2'd0);
          byte_idx_nxt = 2'd0;
          bit_cnt_nxt  = 3'd0;
          state_nxt    = ST_BIT_MARK;
        end
        ST_BIT_MARK: begin
          out_dur_nxt  = cfg.bit_mark;
          out_mark_nxt = 1'b1;
          state_nxt    = ST_BIT_SPACE;
        end
        ST_BIT_SPACE: begin
          out_dur_nxt  = shift_r[0] ? cfg.one_space : cfg.zero_space;
          out_mark_nxt = 1'b0;
          shift_nxt    = shift_r >> 1;
          bit_cnt_nxt  = bit_cnt_r + 3'd1;
          state_nxt    = ST_BIT_MARK;
          if (bit_cnt_r == 3'd7) begin
            if (final_byte) begin
              out_last_nxt = 1'b1;
              state_nxt    = ST_IDLE;
            end else begin
              byte_idx_nxt = byte_idx_r + 2'd1;
              // sync bytes go out plain, data is followed by its complement
              shift_nxt    = is_sync_r ? sync_byte(byte_idx_r + 2'd1)
                                       : (data_r ^ BYTE_INV_MASK);
            end
          end
        end
        ST_TRL_MARK: begin
          out_dur_nxt  = cfg.trl_mark;
          out_mark_nxt = 1'b1;
          out_last_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end
        default: begin
          load      = 1'b0;
          state_nxt = ST_IDLE;
        end
      endcase
    end

    out_valid_nxt = load ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      bit_cnt_r   <= 3'd0;
      byte_idx_r  <= 2'd0;
      is_sync_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      byte_idx_r  <= byte_idx_nxt;
      is_sync_r   <= is_sync_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r    <= shift_nxt;
    data_r     <= data_nxt;
    out_dur_r  <= out_dur_nxt;
    out_mark_r <= out_mark_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.duration_us = out_dur_r;
  assign out_if.is_mark     = out_mark_r;
  assign out_if.last        = out_last_r;

  // a data item starts straight on its first bit mark
  a_data_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_if.mode == MODE_DATA |=> state_r == ST_BIT_MARK)
    else $error("data item did not start on a bit mark");

  // the closing word of an item always returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load && out_last_nxt |=> state_r == ST_IDLE && out_last_r)
    else $error("last word without return to idle");

  // byte position never passes the third sync byte
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BIT_SPACE |-> byte_idx_r <= SYNC_LAST_IDX)
    else $error("byte index out of range");

  // a stalled output word is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_if.ready |-> !load)
    else $error("output word overwritten while stalled");

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: pulse distance frame encoder
// Sends frame start, data byte, frame end and unused items, first from a
// short directed table, then as random frames with some noise mixed in. Every
// duration word that comes out is compared with the words computed here from
// a local copy of the timing registers. The timing starts at reset values,
// then is reloaded: all zero, all ones, mixed extremes and random values.
// ----------------------------------------------------------------------------
module testbench;
  import irpd_pkg::*;

  localparam int          CYCLE_LIMIT  = 800_000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          LONG_HOLD    = 400;
  localparam int          MAX_REPORTS  = 40;
  localparam logic [1:0]  MODE_NONE    = 2'd3;
  localparam logic [IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [IDX_W-1:0] CFG_SPARE_B = 3'd7;
  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h01;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h10;
  localparam logic [BYTE_W-1:0] SYNC_THIRD  = 8'h00;
  localparam logic [BYTE_W-1:0] COMPLEMENT  = 8'hff;

  typedef struct packed {
    logic [DUR_W-1:0] dur;
    logic             mark;
    logic             last;
  } ir_word_t;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_ONE
  } row_check_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [7:0]       data;
    row_check_t       chk;
    logic [DUR_W-1:0] dur;
  } dir_row_t;

  localparam int N_DIRECTED = 19;
  dir_row_t dir_rows [N_DIRECTED] = '{
    '{MODE_END,   8'h00, CHK_ONE,   16'd430},
    '{MODE_NONE,  8'hff, CHK_NONE,  16'd0},
    '{MODE_END,   8'hff, CHK_ONE,   16'd430},
    '{MODE_START, 8'h00, CHK_MODEL, 16'd0},
    '{MODE_DATA,  8'h00, CHK_MODEL, 16'd0},
    '{MODE_DATA,  8'hff, CHK_MODEL, 16'd0},
    '{MODE_DATA,  8'h01, CHK_MODEL, 16'd0},
    '{MODE_DATA,  8'h80, CHK_MODEL, 16'd0},
    '{MODE_DATA,  8'ha5, CHK_MODEL, 16'd0},
    '{MODE_DATA,  8'h5a, CHK_MODEL, 16'd0},
    '{MODE_END,   8'h00, CHK_ONE,   16'd430},
    '{MODE_DATA,  8'h3c, CHK_MODEL, 16'd0},
    '{MODE_START, 8'hff, CHK_MODEL, 16'd0},
    '{MODE_START, 8'h00, CHK_MODEL, 16'd0},
    '{MODE_NONE,  8'h00, CHK_NONE,  16'd0},
    '{MODE_DATA,  8'hc3, CHK_MODEL, 16'd0},
    '{MODE_END,   8'h55, CHK_ONE,   16'd430},
    '{MODE_NONE,  8'h55, CHK_NONE,  16'd0},
    '{MODE_END,   8'haa, CHK_ONE,   16'd430}
  };

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [DUR_W-1:0] cfg_wdata;

  irpd_in_if  in_ch ();
  irpd_out_if out_ch ();

  ir_pulse_distance_frame_encoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  irpd_cfg_t timing;
  ir_word_t  pending_words [$];
  int        mismatches;
  int        reports;
  int        words_checked;
  int        cycle_count;
  int        starts_sent, bytes_sent, ends_sent, unused_sent;
  int        settings_loaded;
  bit        source_idling;
  bit        sink_idling;
  int        hold_requests;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic void add_word(input logic [DUR_W-1:0] dur, input logic mark);
    ir_word_t w;
    w.dur  = dur;
    w.mark = mark;
    w.last = 1'b0;
    pending_words.push_back(w);
  endfunction

  // lsb first, each bit is a mark then a one or zero space
  function automatic void add_byte_bits(input logic [BYTE_W-1:0] b);
    for (int k = 0; k < BYTE_W; k++) begin
      add_word(timing.bit_mark, 1'b1);
      add_word(b[k] ? timing.one_space : timing.zero_space, 1'b0);
    end
  endfunction

  function automatic void encode_item(input logic [1:0] mode, input logic [7:0] data);
    ir_word_t w;
    case (mode)
      MODE_START: begin
        add_word(timing.hdr_mark, 1'b1);
        add_word(timing.hdr_space, 1'b0);
        add_byte_bits(SYNC_FIRST);
        add_byte_bits(SYNC_SECOND);
        add_byte_bits(SYNC_THIRD);
      end
      MODE_DATA: begin
        add_byte_bits(data);
        add_byte_bits(data ^ COMPLEMENT);
      end
      MODE_END: begin
        add_word(timing.trl_mark, 1'b1);
      end
      default: return;
    endcase
    w = pending_words.pop_back();
    w.last = 1'b1;
    pending_words.push_back(w);
  endfunction

  // ------------------------------------------------------------------ checker

  task automatic flag_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (reports < MAX_REPORTS) begin
      reports++;
      $display("%0t mismatch on %s: expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : word_checker
    ir_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_checked++;
      if (pending_words.size() == 0) begin
        flag_mismatch("unexpected word, duration", -1, int'(out_ch.duration_us));
      end else begin
        want = pending_words.pop_front();
        if (out_ch.duration_us !== want.dur)
          flag_mismatch("duration_us", int'(want.dur), int'(out_ch.duration_us));
        if (out_ch.is_mark !== want.mark)
          flag_mismatch("is_mark", int'(want.mark), int'(out_ch.is_mark));
        if (out_ch.last !== want.last)
          flag_mismatch("last", int'(want.last), int'(out_ch.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t timeout with %0d words outstanding", $time, pending_words.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ----------------------------------------------------------- output ready

  initial begin : ready_driver
    int stall_left;
    int hold_left;
    int holds_served;
    stall_left   = 0;
    hold_left    = 0;
    holds_served = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (sink_idling && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------ sender

  task automatic send_item(input logic [1:0] mode, input logic [7:0] data,
                           input bit predict);
    if (source_idling && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= mode;
    in_ch.data_byte <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (predict) encode_item(mode, data);
    case (mode)
      MODE_START: starts_sent++;
      MODE_DATA:  bytes_sent++;
      MODE_END:   ends_sent++;
      default:    unused_sent++;
    endcase
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DUR_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_HDR_MARK:   timing.hdr_mark   = val;
      CFG_HDR_SPACE:  timing.hdr_space  = val;
      CFG_BIT_MARK:   timing.bit_mark   = val;
      CFG_ONE_SPACE:  timing.one_space  = val;
      CFG_ZERO_SPACE: timing.zero_space = val;
      CFG_TRL_MARK:   timing.trl_mark   = val;
      default: ;
    endcase
  endtask

  // spare indexes get junk that must leave every duration alone
  task automatic load_timing(input irpd_cfg_t t, input bit poke_spare);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(CFG_HDR_MARK, t.hdr_mark);
    write_reg(CFG_HDR_SPACE, t.hdr_space);
    write_reg(CFG_BIT_MARK, t.bit_mark);
    write_reg(CFG_ONE_SPACE, t.one_space);
    write_reg(CFG_ZERO_SPACE, t.zero_space);
    write_reg(CFG_TRL_MARK, t.trl_mark);
    if (poke_spare) begin
      write_reg(CFG_SPARE_A, 16'($urandom));
      write_reg(CFG_SPARE_B, 16'($urandom));
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // mostly whole frames with random bytes, some loose items in between
  task automatic run_random(input int n_items);
    int         sent;
    int         k;
    logic [1:0] md;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        send_item(MODE_START, 8'($urandom), 1'b1);
        k = $urandom_range(1, 6);
        repeat (k) send_item(MODE_DATA, 8'($urandom), 1'b1);
        send_item(MODE_END, 8'($urandom), 1'b1);
        sent += k + 2;
      end else begin
        repeat ($urandom_range(1, 3)) begin
          md = 2'($urandom_range(0, 3));
          send_item(md, 8'($urandom), 1'b1);
          if (md != MODE_NONE) sent++;
        end
      end
    end
  endtask

  function automatic irpd_cfg_t random_timing();
    irpd_cfg_t t;
    t.hdr_mark   = 16'($urandom);
    t.hdr_space  = 16'($urandom);
    t.bit_mark   = 16'($urandom);
    t.one_space  = 16'($urandom);
    t.zero_space = 16'($urandom);
    t.trl_mark   = 16'($urandom);
    return t;
  endfunction

  // ------------------------------------------------------------------- main

  initial begin : stimulus
    irpd_cfg_t t;
    ir_word_t  w;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_HDR_MARK;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = MODE_START;
    in_ch.data_byte = '0;
    mismatches      = 0;
    reports         = 0;
    words_checked   = 0;
    cycle_count     = 0;
    starts_sent     = 0;
    bytes_sent      = 0;
    ends_sent       = 0;
    unused_sent     = 0;
    settings_loaded = 0;
    hold_requests   = 0;
    source_idling   = 1'b1;
    sink_idling     = 1'b1;
    timing.hdr_mark   = RST_HDR_MARK;
    timing.hdr_space  = RST_HDR_SPACE;
    timing.bit_mark   = RST_BIT_MARK;
    timing.one_space  = RST_ONE_SPACE;
    timing.zero_space = RST_ZERO_SPACE;
    timing.trl_mark   = RST_TRL_MARK;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // reset timing, directed items first
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_item(dir_rows[i].mode, dir_rows[i].data, dir_rows[i].chk == CHK_MODEL);
      if (dir_rows[i].chk == CHK_ONE) begin
        w.dur  = dir_rows[i].dur;
        w.mark = 1'b1;
        w.last = 1'b1;
        pending_words.push_back(w);
      end
    end
    run_random(40);

    // everything zero; the sink holds off long while items keep coming
    t = '0;
    load_timing(t, 1'b1);
    run_random(20);
    hold_requests++;
    run_random(40);

    // everything at full scale; one pause for a full drain mid phase
    t = '1;
    load_timing(t, 1'b0);
    run_random(30);
    wait_drained();
    run_random(30);

    // mixed extremes, distinct so a swapped register shows up
    t.hdr_mark   = 16'h0001;
    t.hdr_space  = 16'hfffe;
    t.bit_mark   = 16'h8000;
    t.one_space  = 16'h7fff;
    t.zero_space = 16'h0000;
    t.trl_mark   = 16'hffff;
    load_timing(t, 1'b1);
    run_random(60);

    // random timing, only the sink stalls
    source_idling = 1'b0;
    load_timing(random_timing(), 1'b1);
    run_random(60);

    // random timing, both sides at full rate
    sink_idling = 1'b0;
    load_timing(random_timing(), 1'b0);
    run_random(60);

    wait_drained();
    repeat (DRAIN_CYCLES * 2) @(posedge clk);

    $display("items: %0d frame starts, %0d data bytes, %0d frame ends, %0d unused",
             starts_sent, bytes_sent, ends_sent, unused_sent);
    $display("%0d duration words checked under %0d timing loads plus reset values",
             words_checked, settings_loaded);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
